/* hw/rtl/art_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants for the address range table
// opcodes, status codes and sequencer states
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int unsigned DefTableDepth = 256;
	localparam int unsigned DefTagWidth   = 16;
	localparam int unsigned AddrWidth     = 32;
	localparam int unsigned OutTagWidth   = 16;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_OVERLAP = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_PREV_RD,
		S_PREV_CMP,
		S_NEXT_RD,
		S_NEXT_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* hw/rtl/address_range_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_table_core: sorted table of address ranges with tags
// binary search over one synchronous memory, insert by shifting entries up
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// s_axis   in   tdata: operation, first_address, last_address, line_tag
// m_axis   out  tdata: found_tag, hit, status
//
// steps: accept, a read and a compare of the one port memory per search probe
//   (at most log2(entries)+1 probes), close the search; lookup/overlap read and
//   compare the entry below, overlap then the one above; an insert checks the
//   entry below for a duplicate, shifts entries up, writes; the result loads last
// one item at a time; the next beat is taken once the result register is free
// reset clears the entry count, control and result registers; the memory needs no clearing
// a stalled result holds in the output register
module address_range_table_core #(
	parameter int unsigned TABLE_DEPTH = art_pkg::DefTableDepth,
	parameter int unsigned TAG_WIDTH   = art_pkg::DefTagWidth
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [1:0] operation, [33:2] first_address, [65:34] last_address,
	// [81:66] line_tag, [87:82] zero
	input  wire logic [87:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [15:0] found_tag, [16] hit, [18:17] status, [23:19] zero
	output logic [23:0]       m_axis_tdata
);
	import art_pkg::*;

	localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
	localparam int unsigned CntW = IdxW + 1;
	localparam int unsigned EntW = 2 * AddrWidth + TAG_WIDTH;

	// table memory: {tag, end, start}
	logic [EntW-1:0] mem_q [TABLE_DEPTH];
	logic [EntW-1:0] rd_q;
	logic [IdxW-1:0] addr;
	logic            we;
	logic [EntW-1:0] wdata;

	state_t state_q, state_d;
	logic [CntW-1:0] count_q, lo_q, hi_q, ptr_q;
	logic [1:0]      op_q;
	logic [AddrWidth-1:0] first_q, last_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [OutTagWidth-1:0] res_tag_q;
	logic            res_hit_q;
	status_t         res_st_q;
	logic            out_v_q;

	logic [CntW-1:0] mid;
	logic [AddrWidth-1:0] rd_start, rd_end;
	logic [TAG_WIDTH-1:0] rd_tag;
	logic [OutTagWidth-1:0] rd_tag_ext;

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_start   = rd_q[AddrWidth-1:0];
	assign rd_end     = rd_q[2*AddrWidth-1:AddrWidth];
	assign rd_tag     = rd_q[EntW-1:2*AddrWidth];
	assign rd_tag_ext = OutTagWidth'(rd_tag);

	// memory port
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rd_q <= mem_q[addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (s_axis_tvalid && !out_v_q) state_d = S_SRCH_RD;
			S_SRCH_RD:  if (lo_q >= hi_q) begin
				if (op_q == OP_INSERT)
					state_d = (lo_q != '0) ? S_PREV_RD
						: (count_q >= CntW'(TABLE_DEPTH)) ? S_DONE
						: (count_q > lo_q) ? S_SHIFT_RD : S_INS_WR;
				else if (op_q == OP_NONE) state_d = S_DONE;
				else if (lo_q != '0) state_d = S_PREV_RD;
				else state_d = (op_q == OP_OVERLAP && lo_q < count_q) ? S_NEXT_RD : S_DONE;
			end else state_d = S_SRCH_CMP;
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_PREV_RD:  state_d = S_PREV_CMP;
			S_PREV_CMP: begin
				if (op_q == OP_INSERT)
					state_d = (rd_start == first_q) ? S_DONE
						: (count_q >= CntW'(TABLE_DEPTH)) ? S_DONE
						: (count_q > lo_q) ? S_SHIFT_RD : S_INS_WR;
				else if (rd_end >= first_q) state_d = S_DONE;
				else state_d = (op_q == OP_OVERLAP && lo_q < count_q) ? S_NEXT_RD : S_DONE;
			end
			S_NEXT_RD:  state_d = S_NEXT_CMP;
			S_NEXT_CMP: state_d = S_DONE;
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (ptr_q - 1'b1 > lo_q) ? S_SHIFT_RD : S_INS_WR;
			S_INS_WR:   state_d = S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory address and write
	always_comb begin
		addr  = '0;
		we    = 1'b0;
		wdata = rd_q;
		unique case (state_q)
			S_SRCH_RD:  addr = mid[IdxW-1:0];
			S_PREV_RD:  addr = IdxW'(lo_q - 1'b1);
			S_NEXT_RD:  addr = lo_q[IdxW-1:0];
			S_SHIFT_RD: addr = IdxW'(ptr_q - 1'b1);
			S_SHIFT_WR: begin
				addr = ptr_q[IdxW-1:0];
				we   = 1'b1;
			end
			S_INS_WR: begin
				addr  = lo_q[IdxW-1:0];
				we    = 1'b1;
				wdata = {tag_q, last_q, first_q};
			end
			default: addr = '0;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, res_st_q, res_hit_q, res_tag_q};

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_v_q   <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			ptr_q     <= '0;
			res_tag_q <= '0;
			res_hit_q <= 1'b0;
			res_st_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && !out_v_q) begin
					lo_q      <= '0;
					hi_q      <= count_q;
					res_tag_q <= '0;
					res_hit_q <= 1'b0;
					res_st_q  <= ST_OK;
				end
				S_SRCH_RD: if (lo_q >= hi_q) begin
					ptr_q <= count_q;
					if (op_q == OP_INSERT && lo_q == '0 && count_q >= CntW'(TABLE_DEPTH))
						res_st_q <= ST_FULL;
				end else ptr_q <= mid;
				S_SRCH_CMP: begin
					if (rd_start <= first_q) lo_q <= ptr_q + 1'b1;
					else hi_q <= ptr_q;
				end
				S_PREV_CMP: begin
					if (op_q == OP_INSERT) begin
						if (rd_start == first_q) res_st_q <= ST_DUP;
						else if (count_q >= CntW'(TABLE_DEPTH)) res_st_q <= ST_FULL;
					end else if (rd_end >= first_q) begin
						res_tag_q <= rd_tag_ext;
						res_hit_q <= 1'b1;
					end
				end
				S_NEXT_CMP: if (rd_start <= last_q) begin
					res_tag_q <= rd_tag_ext;
					res_hit_q <= 1'b1;
				end
				S_SHIFT_WR: ptr_q <= ptr_q - 1'b1;
				S_INS_WR:   count_q <= count_q + 1'b1;
				S_DONE:     out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// beat payload capture
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_q    <= s_axis_tdata[1:0];
			first_q <= s_axis_tdata[33:2];
			last_q  <= s_axis_tdata[65:34];
			tag_q   <= TAG_WIDTH'(s_axis_tdata[81:66]);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/art_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// art_checker: port-level checks for the address range table
// handshake rules and result encoding
// ----------------------------------------------------------------------------
module art_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [87:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);
	import art_pkg::*;

	// a result beat holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed under stall");

	// a miss never carries a tag
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("tag without hit");

	// a hit only comes with ok status
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[18:17] == ST_OK)
		else $error("hit with error status");

	// one item at a time: no input beat while a result waits
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");

	// an accepted beat yields no result in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");

endmodule

bind address_range_table_core art_checker u_art_checker (.*);
`default_nettype wire
